FILE: design/fcsg_pkg.sv
`default_nettype none

package fcsg_pkg;

    localparam int PC_W = 3;
    localparam int OP_W = 3;
    localparam int CC_W = 3;

    // Datapath operations selected by a control word.
    localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 3'd1;
    localparam logic [OP_W-1:0] OP_RB_INIT = 3'd2;
    localparam logic [OP_W-1:0] OP_RB_STEP = 3'd3;
    localparam logic [OP_W-1:0] OP_EM_INIT = 3'd4;
    localparam logic [OP_W-1:0] OP_EM_RUN  = 3'd5;
    localparam logic [OP_W-1:0] OP_FLUSH   = 3'd6;

    // Jump conditions; when the condition holds the sequencer jumps, else it steps on.
    localparam logic [CC_W-1:0] CC_NEVER         = 3'd0;
    localparam logic [CC_W-1:0] CC_ALWAYS        = 3'd1;
    localparam logic [CC_W-1:0] CC_NO_ACCEPT     = 3'd2;
    localparam logic [CC_W-1:0] CC_CACHE_HIT     = 3'd3;
    localparam logic [CC_W-1:0] CC_RB_BUSY       = 3'd4;
    localparam logic [CC_W-1:0] CC_EM_BUSY       = 3'd5;
    localparam logic [CC_W-1:0] CC_FLUSH_BLOCKED = 3'd6;

    // Program step addresses.
    localparam logic [PC_W-1:0] ST_IDLE    = 3'd0;
    localparam logic [PC_W-1:0] ST_CHECK   = 3'd1;
    localparam logic [PC_W-1:0] ST_RB_INIT = 3'd2;
    localparam logic [PC_W-1:0] ST_RB_STEP = 3'd3;
    localparam logic [PC_W-1:0] ST_EM_INIT = 3'd4;
    localparam logic [PC_W-1:0] ST_EM_RUN  = 3'd5;
    localparam logic [PC_W-1:0] ST_FLUSH   = 3'd6;
    localparam logic [PC_W-1:0] ST_DONE    = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [CC_W-1:0] cond;
        logic [PC_W-1:0] target;
    } fcsg_uword_t;

    typedef struct packed {
        logic       rb_init;
        logic       rb_step;
        logic       rd_en;
        logic [4:0] rd_addr;
        logic [4:0] radius;
    } fcsg_ctrl_t;

    typedef struct packed {
        logic cache_hit;
        logic rb_last;
    } fcsg_stat_t;

    function automatic fcsg_uword_t fcsg_ucode(input logic [PC_W-1:0] pc);
        fcsg_uword_t w;
        case (pc)
            ST_IDLE:    w = '{op: OP_LOAD,    cond: CC_NO_ACCEPT,     target: ST_IDLE};
            ST_CHECK:   w = '{op: OP_NONE,    cond: CC_CACHE_HIT,     target: ST_EM_INIT};
            ST_RB_INIT: w = '{op: OP_RB_INIT, cond: CC_NEVER,         target: ST_IDLE};
            ST_RB_STEP: w = '{op: OP_RB_STEP, cond: CC_RB_BUSY,       target: ST_RB_STEP};
            ST_EM_INIT: w = '{op: OP_EM_INIT, cond: CC_NEVER,         target: ST_IDLE};
            ST_EM_RUN:  w = '{op: OP_EM_RUN,  cond: CC_EM_BUSY,       target: ST_EM_RUN};
            ST_FLUSH:   w = '{op: OP_FLUSH,   cond: CC_FLUSH_BLOCKED, target: ST_FLUSH};
            ST_DONE:    w = '{op: OP_NONE,    cond: CC_ALWAYS,        target: ST_IDLE};
            default:    w = '{op: OP_NONE,    cond: CC_ALWAYS,        target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: design/fcsg_half_width.sv
`default_nettype none

module fcsg_half_width
    import fcsg_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire fcsg_ctrl_t ctrl,
    output fcsg_stat_t      stat,
    output logic [4:0]      rd_data
);

    logic [4:0]  tbl_mem [32];
    logic [4:0]  x_reg, x_next;
    logic [9:0]  x2_reg, x2_next;
    logic [4:0]  dy_reg, dy_next;
    logic [9:0]  dy2_reg, dy2_next;
    logic [9:0]  rr_reg, rr_next;
    logic        cache_valid_reg, cache_valid_next;
    logic [4:0]  cache_r_reg, cache_r_next;
    logic [10:0] sum;
    logic [9:0]  r_sq;
    logic        dec;
    logic        wr_en;

    // The half-width only shrinks as the offset grows, so x walks down while dy walks up.
    assign r_sq  = {5'd0, ctrl.radius} * {5'd0, ctrl.radius};
    assign sum   = {1'b0, x2_reg} + {1'b0, dy2_reg};
    assign dec   = (x_reg != 5'd0) && (sum > {1'b0, rr_reg});
    assign wr_en = ctrl.rb_step && !dec;

    assign stat.cache_hit = cache_valid_reg && (cache_r_reg == ctrl.radius);
    assign stat.rb_last   = !dec && (dy_reg == ctrl.radius);

    always_comb begin
        x_next           = x_reg;
        x2_next          = x2_reg;
        dy_next          = dy_reg;
        dy2_next         = dy2_reg;
        rr_next          = rr_reg;
        cache_valid_next = cache_valid_reg;
        cache_r_next     = cache_r_reg;
        if (ctrl.rb_init) begin
            x_next   = ctrl.radius;
            x2_next  = r_sq;
            rr_next  = r_sq;
            dy_next  = 5'd0;
            dy2_next = 10'd0;
        end else if (ctrl.rb_step) begin
            if (dec) begin
                x_next  = x_reg - 5'd1;
                x2_next = 10'(x2_reg - {4'd0, x_reg, 1'b0} + 10'd1);
            end else if (dy_reg == ctrl.radius) begin
                cache_valid_next = 1'b1;
                cache_r_next     = ctrl.radius;
            end else begin
                dy_next  = dy_reg + 5'd1;
                dy2_next = 10'(dy2_reg + {4'd0, dy_reg, 1'b0} + 10'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cache_valid_reg <= 1'b0;
        end else begin
            cache_valid_reg <= cache_valid_next;
        end
        cache_r_reg <= cache_r_next;
        x_reg       <= x_next;
        x2_reg      <= x2_next;
        dy_reg      <= dy_next;
        dy2_reg     <= dy2_next;
        rr_reg      <= rr_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tbl_mem[dy_reg] <= x_reg;
        end
        if (ctrl.rd_en) begin
            rd_data <= tbl_mem[ctrl.rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/filled_circle_span_generator_unit.sv
`default_nettype none

// Channel   Direction  Ports            Contents
// request   in         s_axis_t*        one circle: centre, radius, fill colour
// span      out        m_axis_t*        one horizontal span, tlast on the circle's final span
//
// A request is paced by the span loop, which issues one table read per row of a circle of
// clamped radius r. When r differs from the cached radius, a table rebuild comes first:
// a set-up step, then the steps of the half-width search.
// Reset clears the sequencer, the pipeline and the cached radius; the table is rewritten
// before use. A stalled output holds the span loop until the span register frees up.

module filled_circle_span_generator_unit
    import fcsg_pkg::*;
#(
    parameter int MAX_RADIUS = 31,
    parameter int SCREEN_W   = 240,
    parameter int SCREEN_H   = 320
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // center_x[11:0], center_y[23:12], radius[28:24], fill_color[44:29], zero[47:45]
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // row[9:0], col_start[19:10], col_end[29:20], pixel_word[45:30], zero[47:46]
    output logic [47:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    localparam logic [4:0]         MAX_R    = 5'(MAX_RADIUS);
    localparam logic signed [12:0] ROW_LIM  = 13'(SCREEN_H);
    localparam logic signed [12:0] COL_LAST = 13'(SCREEN_W - 1);

    logic [PC_W-1:0]   pc_reg, pc_next;
    fcsg_uword_t       uw;
    logic              cond_true;
    fcsg_ctrl_t        ctrl;
    fcsg_stat_t        stat;
    logic [4:0]        rd_data;

    logic signed [11:0] cx_reg, cx_next;
    logic signed [11:0] cy_reg, cy_next;
    logic [4:0]         r_reg, r_next;
    logic [15:0]        pix_reg, pix_next;

    logic signed [5:0]  dy_reg, dy_next;
    logic               issue_done_reg, issue_done_next;
    logic               s1_valid_reg, s1_valid_next;
    logic signed [12:0] s1_y_reg, s1_y_next;

    logic               pend_valid_reg, pend_valid_next;
    logic [9:0]         pend_row_reg, pend_row_next;
    logic [9:0]         pend_start_reg, pend_start_next;
    logic [9:0]         pend_end_reg, pend_end_next;

    logic               out_valid_reg, out_valid_next;
    logic [9:0]         out_row_reg, out_row_next;
    logic [9:0]         out_start_reg, out_start_next;
    logic [9:0]         out_end_reg, out_end_next;
    logic [15:0]        out_pix_reg, out_pix_next;
    logic               out_last_reg, out_last_next;

    logic               accept;
    logic               out_free;
    logic [4:0]         in_radius;
    logic [5:0]         dy_abs;
    logic signed [12:0] cx_ext, dx_ext, x0_raw, x1_raw;
    logic               cand_ok;
    logic [9:0]         cand_start, cand_end;
    logic               issue;
    logic               advance;

    assign uw            = fcsg_ucode(pc_reg);
    assign s_axis_tready = (uw.op == OP_LOAD);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_radius     = (s_axis_tdata[28:24] > MAX_R) ? MAX_R : s_axis_tdata[28:24];

    assign dy_abs = dy_reg[5] ? 6'(-dy_reg) : 6'(dy_reg);
    assign issue  = (uw.op == OP_EM_RUN) && !issue_done_reg;

    assign cx_ext     = {cx_reg[11], cx_reg};
    assign dx_ext     = {8'd0, rd_data};
    assign x0_raw     = cx_ext - dx_ext;
    assign x1_raw     = cx_ext + dx_ext;
    assign cand_ok    = s1_valid_reg && (s1_y_reg >= 13'sd0) && (s1_y_reg < ROW_LIM)
                        && (x1_raw >= 13'sd0) && (x0_raw <= COL_LAST);
    assign cand_start = (x0_raw < 13'sd0) ? 10'd0 : x0_raw[9:0];
    assign cand_end   = (x1_raw > COL_LAST) ? COL_LAST[9:0] : x1_raw[9:0];

    // A new span can only displace the pending one if the output register is free.
    assign advance = !(cand_ok && pend_valid_reg && !out_free);

    assign ctrl.rb_init = (uw.op == OP_RB_INIT);
    assign ctrl.rb_step = (uw.op == OP_RB_STEP);
    assign ctrl.rd_en   = issue && advance;
    assign ctrl.rd_addr = dy_abs[4:0];
    assign ctrl.radius  = r_reg;

    fcsg_half_width u_half_width (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat),
        .rd_data (rd_data)
    );

    always_comb begin
        case (uw.cond)
            CC_NEVER:         cond_true = 1'b0;
            CC_ALWAYS:        cond_true = 1'b1;
            CC_NO_ACCEPT:     cond_true = !accept;
            CC_CACHE_HIT:     cond_true = stat.cache_hit;
            CC_RB_BUSY:       cond_true = !stat.rb_last;
            CC_EM_BUSY:       cond_true = !issue_done_reg || s1_valid_reg;
            CC_FLUSH_BLOCKED: cond_true = pend_valid_reg && !out_free;
            default:          cond_true = 1'b0;
        endcase
        pc_next = cond_true ? uw.target : pc_reg + 3'd1;
    end

    always_comb begin
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        r_next          = r_reg;
        pix_next        = pix_reg;
        dy_next         = dy_reg;
        issue_done_next = issue_done_reg;
        s1_valid_next   = s1_valid_reg;
        s1_y_next       = s1_y_reg;
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        pend_start_next = pend_start_reg;
        pend_end_next   = pend_end_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_row_next    = out_row_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_pix_next    = out_pix_reg;
        out_last_next   = out_last_reg;

        case (uw.op)
            OP_LOAD: begin
                if (accept) begin
                    cx_next  = s_axis_tdata[11:0];
                    cy_next  = s_axis_tdata[23:12];
                    r_next   = in_radius;
                    pix_next = {s_axis_tdata[36:29], s_axis_tdata[44:37]};
                end
            end
            OP_EM_INIT: begin
                dy_next         = -$signed({1'b0, r_reg});
                issue_done_next = 1'b0;
                s1_valid_next   = 1'b0;
                pend_valid_next = 1'b0;
            end
            OP_EM_RUN: begin
                if (advance) begin
                    s1_valid_next = issue;
                    s1_y_next     = {cy_reg[11], cy_reg} + {{7{dy_reg[5]}}, dy_reg};
                    if (issue) begin
                        dy_next = dy_reg + 6'sd1;
                        if (dy_reg == $signed({1'b0, r_reg})) begin
                            issue_done_next = 1'b1;
                        end
                    end
                    if (cand_ok) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_row_next   = pend_row_reg;
                            out_start_next = pend_start_reg;
                            out_end_next   = pend_end_reg;
                            out_pix_next   = pix_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_row_next   = s1_y_reg[9:0];
                        pend_start_next = cand_start;
                        pend_end_next   = cand_end;
                    end
                end
            end
            OP_FLUSH: begin
                if (pend_valid_reg && out_free) begin
                    out_valid_next  = 1'b1;
                    out_row_next    = pend_row_reg;
                    out_start_next  = pend_start_reg;
                    out_end_next    = pend_end_reg;
                    out_pix_next    = pix_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= ST_IDLE;
            issue_done_reg <= 1'b1;
            s1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pc_reg         <= pc_next;
            issue_done_reg <= issue_done_next;
            s1_valid_reg   <= s1_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        r_reg          <= r_next;
        pix_reg        <= pix_next;
        dy_reg         <= dy_next;
        s1_y_reg       <= s1_y_next;
        pend_row_reg   <= pend_row_next;
        pend_start_reg <= pend_start_next;
        pend_end_reg   <= pend_end_next;
        out_row_reg    <= out_row_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
        out_pix_reg    <= out_pix_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_pix_reg, out_end_reg, out_start_reg, out_row_reg};

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> (!pend_valid_reg && !s1_valid_reg))
        else $error("request taken while spans of the previous circle are in flight");

    a_stage_in_loop: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (pc_reg == ST_EM_RUN))
        else $error("row stage valid outside the span loop");

    a_span_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (out_start_reg <= out_end_reg))
        else $error("span starts after it ends");

endmodule

`default_nettype wire
